// ===== design/iras_pkg.sv =====
// Shared types and constants for the indexed register access sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package iras_pkg;

  localparam int unsigned REG_W    = 11;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FMT_W    = 2;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLY = 2'd2;

  // address formats
  localparam logic [FMT_W-1:0] FMT_PLAIN = 2'd0;
  localparam logic [FMT_W-1:0] FMT_TWO   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_THREE = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FINAL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STRAY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd4;

  // configuration reset values
  localparam logic [REG_W-1:0]  PRIMARY_RST   = 11'd201;
  localparam logic [REG_W-1:0]  SECONDARY_RST = 11'd202;
  localparam logic [REG_W-1:0]  HIGH_RST      = 11'd203;
  localparam logic [REG_W-1:0]  LOW_RST       = 11'd204;
  localparam logic [IDX_W-1:0]  OFFSET_RST    = 8'd100;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LAST      = 4'd1,
    PH_SI_RD     = 4'd2,
    PH_STROBE_RD = 4'd3,
    PH_READ_HI   = 4'd4,
    PH_FINISH_RD = 4'd5,
    PH_MSB_RD    = 4'd6,
    PH_LSB_RD    = 4'd7,
    PH_SI_WR     = 4'd8,
    PH_HI_WR     = 4'd9,
    PH_LO_WR     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] primary_index_reg;
    logic [REG_W-1:0] secondary_index_reg;
    logic [REG_W-1:0] high_value_reg;
    logic [REG_W-1:0] low_value_reg;
    logic [IDX_W-1:0] read_offset;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FMT_W-1:0]  address_format;
    logic [REG_W-1:0]  plain_register;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_arg;
    logic [IDX_W-1:0]  third_arg;
    logic [DATA_W-1:0] write_data;
    logic [BYTE_W-1:0] reply_value;
    logic [BYTE_W-1:0] reply_status;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [REG_W-1:0]  target_register;
    logic [DATA_W-1:0] target_data;
    logic [DATA_W-1:0] result_value;
    logic [BYTE_W-1:0] result_status;
    logic              busy_clash;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/iras_req_if.sv =====
// Request channel: valid/ready handshake with the request payload fields.
// Depends on iras_pkg for field widths.
`default_nettype none

interface iras_req_if
  import iras_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [FMT_W-1:0]  address_format;
  logic [REG_W-1:0]  plain_register;
  logic [IDX_W-1:0]  first_index;
  logic [IDX_W-1:0]  second_arg;
  logic [IDX_W-1:0]  third_arg;
  logic [DATA_W-1:0] write_data;
  logic [BYTE_W-1:0] reply_value;
  logic [BYTE_W-1:0] reply_status;

  modport source (
    output valid, mode, address_format, plain_register, first_index, second_arg,
           third_arg, write_data, reply_value, reply_status,
    input  ready
  );

  modport sink (
    input  valid, mode, address_format, plain_register, first_index, second_arg,
           third_arg, write_data, reply_value, reply_status,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/iras_rsp_if.sv =====
// Result channel: valid/ready handshake with the result payload fields.
// Depends on iras_pkg for field widths.
`default_nettype none

interface iras_rsp_if
  import iras_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [REG_W-1:0]  target_register;
  logic [DATA_W-1:0] target_data;
  logic [DATA_W-1:0] result_value;
  logic [BYTE_W-1:0] result_status;
  logic              busy_clash;

  modport source (
    output valid, action, target_register, target_data, result_value,
           result_status, busy_clash,
    input  ready
  );

  modport sink (
    input  valid, action, target_register, target_data, result_value,
           result_status, busy_clash,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/iras_cfg.sv =====
// Configuration register file: five registers written by index.
// Depends on iras_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module iras_cfg
  import iras_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primary_index_reg   <= PRIMARY_RST;
      cfg.secondary_index_reg <= SECONDARY_RST;
      cfg.high_value_reg      <= HIGH_RST;
      cfg.low_value_reg       <= LOW_RST;
      cfg.read_offset         <= OFFSET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRIMARY:   cfg.primary_index_reg   <= cfg_data;
        CFG_SECONDARY: cfg.secondary_index_reg <= cfg_data;
        CFG_HIGH:      cfg.high_value_reg      <= cfg_data;
        CFG_LOW:       cfg.low_value_reg       <= cfg_data;
        CFG_OFFSET:    cfg.read_offset         <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/iras_seq.sv =====
// Chain sequencer: phase register, saved request fields and next-step logic.
// Depends on iras_pkg (phase_t, req_t, rsp_t, cfg_t, codes).
`default_nettype none

module iras_seq
  import iras_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output logic      emit,
  output rsp_t      rsp
);

  phase_t            phase, phase_next;
  logic [FMT_W-1:0]  saved_format, saved_format_next;
  logic [IDX_W-1:0]  saved_first, saved_first_next;
  logic [IDX_W-1:0]  saved_second, saved_second_next;
  logic [IDX_W-1:0]  saved_third, saved_third_next;
  logic [DATA_W-1:0] saved_data, saved_data_next;
  logic [BYTE_W-1:0] upper_byte, upper_byte_next;

  logic              three;
  logic [FMT_W-1:0]  fmt;
  logic              clash;
  logic [REG_W-1:0]  read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      saved_format <= FMT_PLAIN;
      saved_first  <= '0;
      saved_second <= '0;
      saved_third  <= '0;
      saved_data   <= '0;
      upper_byte   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      saved_format <= saved_format_next;
      saved_first  <= saved_first_next;
      saved_second <= saved_second_next;
      saved_third  <= saved_third_next;
      saved_data   <= saved_data_next;
      upper_byte   <= upper_byte_next;
    end
  end

  always_comb begin
    three      = (saved_format == FMT_THREE);
    fmt        = (req.address_format == FMT_TWO || req.address_format == FMT_THREE)
                 ? req.address_format : FMT_PLAIN;
    clash      = (phase != PH_IDLE);
    // index sum is not wrapped, it reaches up to 510
    read_index = REG_W'(req.first_index) + REG_W'(cfg.read_offset);

    phase_next        = phase;
    saved_format_next = saved_format;
    saved_first_next  = saved_first;
    saved_second_next = saved_second;
    saved_third_next  = saved_third;
    saved_data_next   = saved_data;
    upper_byte_next   = upper_byte;
    emit              = 1'b0;
    rsp               = '0;

    case (req.mode)
      MODE_WRITE, MODE_READ: begin
        emit              = 1'b1;
        rsp.busy_clash    = clash;
        saved_format_next = fmt;
        saved_first_next  = req.first_index;
        saved_second_next = req.second_arg;
        saved_third_next  = req.third_arg;
        saved_data_next   = req.write_data;
        upper_byte_next   = '0;
        if (fmt == FMT_PLAIN) begin
          phase_next          = PH_LAST;
          rsp.target_register = req.plain_register;
          if (req.mode == MODE_WRITE) begin
            rsp.action      = ACT_WRITE;
            rsp.target_data = req.write_data;
          end else begin
            rsp.action = ACT_READ;
          end
        end else if (req.mode == MODE_WRITE) begin
          phase_next          = PH_SI_WR;
          rsp.action          = ACT_WRITE;
          rsp.target_register = cfg.primary_index_reg;
          rsp.target_data     = DATA_W'(req.first_index);
        end else begin
          phase_next          = (fmt == FMT_TWO) ? PH_SI_RD : PH_MSB_RD;
          rsp.action          = ACT_WRITE;
          rsp.target_register = cfg.primary_index_reg;
          rsp.target_data     = DATA_W'(read_index);
        end
      end
      MODE_REPLY: begin
        emit = 1'b1;
        case (phase)
          PH_SI_RD: begin
            phase_next          = PH_STROBE_RD;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.secondary_index_reg;
            rsp.target_data     = DATA_W'(saved_second);
          end
          PH_STROBE_RD: begin
            phase_next          = PH_READ_HI;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.low_value_reg;
            rsp.target_data     = DATA_W'(cfg.read_offset);
          end
          PH_READ_HI: begin
            phase_next          = PH_FINISH_RD;
            rsp.action          = ACT_READ;
            rsp.target_register = cfg.high_value_reg;
          end
          PH_FINISH_RD: begin
            phase_next = PH_LAST;
            rsp.action = ACT_READ;
            if (three) begin
              upper_byte_next     = '0;
              rsp.target_register = cfg.secondary_index_reg;
            end else begin
              upper_byte_next     = req.reply_value;
              rsp.target_register = cfg.low_value_reg;
            end
          end
          PH_MSB_RD: begin
            phase_next          = PH_LSB_RD;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.high_value_reg;
            rsp.target_data     = DATA_W'(saved_second);
          end
          PH_LSB_RD: begin
            phase_next          = PH_FINISH_RD;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.low_value_reg;
            rsp.target_data     = DATA_W'(saved_third);
          end
          PH_SI_WR: begin
            phase_next          = PH_HI_WR;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.secondary_index_reg;
            rsp.target_data     = three ? saved_data : DATA_W'(saved_second);
          end
          PH_HI_WR: begin
            phase_next          = PH_LO_WR;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.high_value_reg;
            rsp.target_data     = three ? DATA_W'(saved_second)
                                        : DATA_W'(saved_data[DATA_W-1:BYTE_W]);
          end
          PH_LO_WR: begin
            phase_next          = PH_LAST;
            rsp.action          = ACT_WRITE;
            rsp.target_register = cfg.low_value_reg;
            rsp.target_data     = three ? DATA_W'(saved_third)
                                        : DATA_W'(saved_data[BYTE_W-1:0]);
          end
          PH_LAST: begin
            phase_next        = PH_IDLE;
            rsp.action        = ACT_FINAL;
            rsp.result_value  = {upper_byte, req.reply_value};
            rsp.result_status = req.reply_status;
          end
          default: begin
            // reply with no chain running
            phase_next = PH_IDLE;
            rsp.action = ACT_STRAY;
          end
        endcase
      end
      default: ; // unused mode: drop the request, no result
    endcase
  end

endmodule

`default_nettype wire

// ===== design/iras_out.sv =====
// Result register stage: holds one result until the receiver takes it.
// Depends on iras_pkg (rsp_t).
`default_nettype none

module iras_out
  import iras_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire rsp_t rsp_in,
  output logic      room,
  output logic      valid,
  input  wire logic ready,
  output rsp_t      rsp
);

  assign room = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      rsp <= rsp_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/indexed_register_access_sequencer_core.sv =====
// Indexed register access sequencer, top level.
// Depends on iras_pkg, iras_req_if, iras_rsp_if, iras_cfg, iras_seq, iras_out.
//
// Usage:
//   req  - request channel (sink). Each request is a start (write or read) or
//          a reply from the downstream programmer. A start opens a chain of
//          single-register accesses; every reply advances the chain by one
//          step, and the reply after the last access yields the final reply.
//   rsp  - result channel (source). One result per start or reply; a request
//          of the unused mode is taken and yields nothing.
//   cfg_write/cfg_index/cfg_data - register writes, taken at any edge with
//          cfg_write high; change them only while no chain step is in flight.
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled. The phase and saved
//   fields update in the accept cycle; the result register is the only buffer.
// Stall: req.ready is high while the result register is empty or being
//   taken in the same cycle; a stalled receiver holds the result and blocks
//   new requests until it is drained.
// Reset (rst, synchronous): phase returns to idle, saved fields clear, the
//   result register empties, and configuration takes its default values.
// A start during a running chain flags busy_clash and replaces the chain; a
//   reply with no chain running returns the stray-reply action and stays idle.
`default_nettype none

module indexed_register_access_sequencer_core
  import iras_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  iras_req_if.sink                  req,
  iras_rsp_if.source                rsp,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  cfg_t cfg;
  req_t req_bus;
  rsp_t step_rsp;
  rsp_t held_rsp;
  logic step_emit;
  logic room;
  logic take;

  // accept whenever the result register can take the outcome
  assign req.ready = room;
  assign take      = req.valid && room;

  assign req_bus.mode           = req.mode;
  assign req_bus.address_format = req.address_format;
  assign req_bus.plain_register = req.plain_register;
  assign req_bus.first_index    = req.first_index;
  assign req_bus.second_arg     = req.second_arg;
  assign req_bus.third_arg      = req.third_arg;
  assign req_bus.write_data     = req.write_data;
  assign req_bus.reply_value    = req.reply_value;
  assign req_bus.reply_status   = req.reply_status;

  iras_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iras_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req_bus),
    .cfg  (cfg),
    .emit (step_emit),
    .rsp  (step_rsp)
  );

  // hold the result until the receiver takes it
  iras_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take && step_emit),
    .rsp_in (step_rsp),
    .room   (room),
    .valid  (rsp.valid),
    .ready  (rsp.ready),
    .rsp    (held_rsp)
  );

  assign rsp.action          = held_rsp.action;
  assign rsp.target_register = held_rsp.target_register;
  assign rsp.target_data     = held_rsp.target_data;
  assign rsp.result_value    = held_rsp.result_value;
  assign rsp.result_status   = held_rsp.result_status;
  assign rsp.busy_clash      = held_rsp.busy_clash;

endmodule

`default_nettype wire

// ===== verif/tb_indexed_register_access_sequencer_core.sv =====
// Self-checking testbench for indexed_register_access_sequencer_core.
// Needs iras_pkg, iras_req_if, iras_rsp_if and the core; a local model of the
// access chains predicts unpinned results; all are checked as they are taken.
`default_nettype none

module tb_indexed_register_access_sequencer_core;
  import iras_pkg::*;

  // Codes the package leaves unnamed: the ignored mode and the unknown format.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [FMT_W-1:0]  FMT_UNKNOWN = 2'd3;

  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_REQUESTS  = 155;
  localparam int SETTLE_CYCLES   = 4;

  // One row of the directed table: the request and, where it is obvious, the
  // result pinned by hand instead of taken from the local model.
  typedef struct packed {
    req_t rq;
    bit   pinned;
    rsp_t want;
  } plan_row_t;

  localparam plan_row_t PLAN [25] = '{
    // stray reply straight out of reset
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0}, 1'b1,
      '{ACT_STRAY, 11'd0, 16'd0, 16'd0, 8'd0, 1'b0}},
    // ignored mode, every field at its top value: no result
    '{'{MODE_UNUSED, FMT_UNKNOWN, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF},
      1'b0, '0},
    // pass-through write at the top register with full data, then its reply
    '{'{MODE_WRITE, FMT_PLAIN, 11'd1024, 8'd0, 8'd0, 8'd0, 16'hFFFF, 8'd0, 8'd0}, 1'b1,
      '{ACT_WRITE, 11'd1024, 16'hFFFF, 16'd0, 8'd0, 1'b0}},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'hFF, 8'hFF}, 1'b1,
      '{ACT_FINAL, 11'd0, 16'd0, 16'h00FF, 8'hFF, 1'b0}},
    // unknown format falls back to pass-through; read of the lowest register
    '{'{MODE_READ, FMT_UNKNOWN, 11'd1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'd0}, 1'b1,
      '{ACT_READ, 11'd1, 16'd0, 16'd0, 8'd0, 1'b0}},
    // start while the read above still waits: flag the clash, run two-index write
    '{'{MODE_WRITE, FMT_TWO, 11'd0, 8'hFF, 8'h00, 8'h00, 16'hA55A, 8'd0, 8'd0}, 1'b1,
      '{ACT_WRITE, PRIMARY_RST, 16'h00FF, 16'd0, 8'd0, 1'b1}},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h12, 8'h34}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h56, 8'h78}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h9A, 8'hBC}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h80, 8'h01}, 1'b0, '0},
    // two-index read: the index sum runs past 255 without wrapping
    '{'{MODE_READ, FMT_TWO, 11'd0, 8'hFF, 8'h5A, 8'h00, 16'd0, 8'd0, 8'd0}, 1'b1,
      '{ACT_WRITE, PRIMARY_RST, 16'd355, 16'd0, 8'd0, 1'b0}},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h01, 8'h02}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h03, 8'h04}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h05, 8'h06}, 1'b0, '0},
    // this reply carries the high byte of the read-back value
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'hAB, 8'h07}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'hCD, 8'h00}, 1'b1,
      '{ACT_FINAL, 11'd0, 16'd0, 16'hABCD, 8'h00, 1'b0}},
    // three-index write, cut short after two steps
    '{'{MODE_WRITE, FMT_THREE, 11'd0, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'd0}, 1'b1,
      '{ACT_WRITE, PRIMARY_RST, 16'd0, 16'd0, 8'd0, 1'b0}},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h11, 8'h22}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h33, 8'h44}, 1'b0, '0},
    // three-index read replaces it, with the clash flag
    '{'{MODE_READ, FMT_THREE, 11'd0, 8'h80, 8'h01, 8'hFE, 16'd0, 8'd0, 8'd0}, 1'b1,
      '{ACT_WRITE, PRIMARY_RST, 16'd228, 16'd0, 8'd0, 1'b1}},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h55, 8'h66}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h77, 8'h88}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'hEE, 8'h99}, 1'b0, '0},
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'hFF, 8'hFE}, 1'b0, '0},
    // one reply too many: stray again
    '{'{MODE_REPLY, FMT_PLAIN, 11'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'h42, 8'h24}, 1'b1,
      '{ACT_STRAY, 11'd0, 16'd0, 16'd0, 8'd0, 1'b0}}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  iras_req_if req_ch ();
  iras_rsp_if rsp_ch ();

  indexed_register_access_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the register file and chain state, kept in step with the core.
  cfg_t             model_cfg;
  phase_t           chain_phase;
  logic [FMT_W-1:0] chain_fmt;
  logic [IDX_W-1:0] chain_first;
  logic [IDX_W-1:0] chain_second;
  logic [IDX_W-1:0] chain_third;
  logic [DATA_W-1:0] chain_data;
  logic [BYTE_W-1:0] chain_upper;

  rsp_t awaited_actions [$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures;
  int requests_sent;
  int results_checked;
  int finals_seen;
  int clashes_seen;
  int strays_seen;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one accepted request and advance the chain state.
  // Return 0 when the request yields nothing.
  function automatic bit next_access(input req_t r, output rsp_t e);
    logic [FMT_W-1:0] fmt;
    bit               three;
    e     = '0;
    three = (chain_fmt == FMT_THREE);
    if (r.mode == MODE_WRITE || r.mode == MODE_READ) begin
      fmt = (r.address_format == FMT_UNKNOWN) ? FMT_PLAIN : r.address_format;
      e.busy_clash = (chain_phase != PH_IDLE);
      chain_fmt    = fmt;
      chain_first  = r.first_index;
      chain_second = r.second_arg;
      chain_third  = r.third_arg;
      chain_data   = r.write_data;
      chain_upper  = '0;
      if (fmt == FMT_PLAIN) begin
        chain_phase       = PH_LAST;
        e.target_register = r.plain_register;
        if (r.mode == MODE_WRITE) begin
          e.action      = ACT_WRITE;
          e.target_data = r.write_data;
        end else begin
          e.action = ACT_READ;
        end
      end else begin
        // Every indexed chain opens by writing the primary index.
        e.action          = ACT_WRITE;
        e.target_register = model_cfg.primary_index_reg;
        if (r.mode == MODE_WRITE) begin
          chain_phase   = PH_SI_WR;
          e.target_data = DATA_W'(chain_first);
        end else begin
          chain_phase   = (fmt == FMT_TWO) ? PH_SI_RD : PH_MSB_RD;
          e.target_data = DATA_W'(chain_first) + DATA_W'(model_cfg.read_offset);
        end
      end
      return 1'b1;
    end
    if (r.mode != MODE_REPLY) return 1'b0;

    e.action = ACT_WRITE;
    case (chain_phase)
      PH_SI_RD: begin
        chain_phase       = PH_STROBE_RD;
        e.target_register = model_cfg.secondary_index_reg;
        e.target_data     = DATA_W'(chain_second);
      end
      PH_STROBE_RD: begin
        chain_phase       = PH_READ_HI;
        e.target_register = model_cfg.low_value_reg;
        e.target_data     = DATA_W'(model_cfg.read_offset);
      end
      PH_READ_HI: begin
        chain_phase       = PH_FINISH_RD;
        e.action          = ACT_READ;
        e.target_register = model_cfg.high_value_reg;
      end
      PH_FINISH_RD: begin
        // Two-index reads latch the high byte here; three-index reads do not.
        chain_phase = PH_LAST;
        e.action    = ACT_READ;
        if (three) begin
          chain_upper       = '0;
          e.target_register = model_cfg.secondary_index_reg;
        end else begin
          chain_upper       = r.reply_value;
          e.target_register = model_cfg.low_value_reg;
        end
      end
      PH_MSB_RD: begin
        chain_phase       = PH_LSB_RD;
        e.target_register = model_cfg.high_value_reg;
        e.target_data     = DATA_W'(chain_second);
      end
      PH_LSB_RD: begin
        chain_phase       = PH_FINISH_RD;
        e.target_register = model_cfg.low_value_reg;
        e.target_data     = DATA_W'(chain_third);
      end
      PH_SI_WR: begin
        chain_phase       = PH_HI_WR;
        e.target_register = model_cfg.secondary_index_reg;
        e.target_data     = three ? chain_data : DATA_W'(chain_second);
      end
      PH_HI_WR: begin
        chain_phase       = PH_LO_WR;
        e.target_register = model_cfg.high_value_reg;
        e.target_data     = three ? DATA_W'(chain_second) : (chain_data >> 8);
      end
      PH_LO_WR: begin
        chain_phase       = PH_LAST;
        e.target_register = model_cfg.low_value_reg;
        e.target_data     = three ? DATA_W'(chain_third) : (chain_data & 16'h00FF);
      end
      PH_LAST: begin
        chain_phase     = PH_IDLE;
        e.action        = ACT_FINAL;
        e.result_value  = {chain_upper, r.reply_value};
        e.result_status = r.reply_status;
      end
      default: begin
        chain_phase = PH_IDLE;
        e.action    = ACT_STRAY;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic req_t random_request(input logic [MODE_W-1:0] m);
    req_t r;
    r.mode           = m;
    r.address_format = FMT_W'($urandom);
    r.plain_register = REG_W'($urandom);
    r.first_index    = IDX_W'($urandom);
    r.second_arg     = IDX_W'($urandom);
    r.third_arg      = IDX_W'($urandom);
    r.write_data     = DATA_W'($urandom);
    r.reply_value    = BYTE_W'($urandom);
    r.reply_status   = BYTE_W'($urandom);
    return r;
  endfunction

  // Offer one request after a random gap, hold it until taken, then predict.
  task automatic send_request(input req_t r, input bit pinned = 1'b0,
                              input rsp_t pinned_want = '0);
    rsp_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.mode           <= r.mode;
    req_ch.address_format <= r.address_format;
    req_ch.plain_register <= r.plain_register;
    req_ch.first_index    <= r.first_index;
    req_ch.second_arg     <= r.second_arg;
    req_ch.third_arg      <= r.third_arg;
    req_ch.write_data     <= r.write_data;
    req_ch.reply_value    <= r.reply_value;
    req_ch.reply_status   <= r.reply_status;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
    if (next_access(r, want)) awaited_actions.push_back(pinned ? pinned_want : want);
    @(negedge clk);
  endtask

  // Drop valid, let every awaited result drain, then idle before returning
  // so that nothing is in flight when the registers change.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (awaited_actions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_PRIMARY:   model_cfg.primary_index_reg   = value;
      CFG_SECONDARY: model_cfg.secondary_index_reg = value;
      CFG_HIGH:      model_cfg.high_value_reg      = value;
      CFG_LOW:       model_cfg.low_value_reg       = value;
      CFG_OFFSET:    model_cfg.read_offset         = IDX_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Load one setting: both extremes, the defaults, a fixed mix and random mixes.
  task automatic apply_setting(input int n);
    cfg_t s;
    case (n)
      0: s = '{11'd1, 11'd1, 11'd1, 11'd1, 8'd0};
      1: s = '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 8'd255};
      3: s = '{PRIMARY_RST, SECONDARY_RST, HIGH_RST, LOW_RST, OFFSET_RST};
      5: s = '{11'd1024, 11'd1, 11'd1024, 11'd1, 8'd255};
      default: begin
        s.primary_index_reg   = REG_W'($urandom_range(1, 1024));
        s.secondary_index_reg = REG_W'($urandom_range(1, 1024));
        s.high_value_reg      = REG_W'($urandom_range(1, 1024));
        s.low_value_reg       = REG_W'($urandom_range(1, 1024));
        s.read_offset         = IDX_W'($urandom_range(0, 255));
      end
    endcase
    write_register(CFG_PRIMARY, s.primary_index_reg);
    write_register(CFG_SECONDARY, s.secondary_index_reg);
    write_register(CFG_HIGH, s.high_value_reg);
    write_register(CFG_LOW, s.low_value_reg);
    write_register(CFG_OFFSET, REG_W'(s.read_offset));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Mostly complete chains with random content; some cut short so the next
  // start clashes, plus stray replies and ignored-mode noise.
  task automatic run_random_traffic(input int quota);
    int   sent;
    int   steps;
    int   pick;
    req_t r;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_request(random_request(MODE_UNUSED));
      end else if (pick < 12) begin
        send_request(random_request(MODE_REPLY));
        sent++;
      end else begin
        r = random_request($urandom_range(0, 1) ? MODE_READ : MODE_WRITE);
        if (r.address_format == FMT_TWO) steps = (r.mode == MODE_WRITE) ? 4 : 5;
        else if (r.address_format == FMT_THREE) steps = 4;
        else steps = 1;
        if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps - 1);
        send_request(r);
        repeat (steps) send_request(random_request(MODE_REPLY));
        sent += 1 + steps;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Result receiver: random stalls, driven at the falling edge.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every taken result against the oldest awaited one.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        results_checked++;
        if (rsp_ch.action == ACT_FINAL) finals_seen++;
        if (rsp_ch.action == ACT_STRAY) strays_seen++;
        if (rsp_ch.busy_clash) clashes_seen++;
        if (awaited_actions.size() == 0) begin
          $error("result with action %0d arrived with nothing awaited", rsp_ch.action);
          failures++;
        end else begin
          want = awaited_actions.pop_front();
          check_field("action", DATA_W'(want.action), DATA_W'(rsp_ch.action));
          check_field("target_register", DATA_W'(want.target_register),
                      DATA_W'(rsp_ch.target_register));
          check_field("target_data", want.target_data, rsp_ch.target_data);
          check_field("result_value", want.result_value, rsp_ch.result_value);
          check_field("result_status", DATA_W'(want.result_status),
                      DATA_W'(rsp_ch.result_status));
          check_field("busy_clash", DATA_W'(want.busy_clash), DATA_W'(rsp_ch.busy_clash));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases under changing
  // register settings and idle profiles.
  initial begin
    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.mode           <= '0;
    req_ch.address_format <= '0;
    req_ch.plain_register <= '0;
    req_ch.first_index    <= '0;
    req_ch.second_arg     <= '0;
    req_ch.third_arg      <= '0;
    req_ch.write_data     <= '0;
    req_ch.reply_value    <= '0;
    req_ch.reply_status   <= '0;
    model_cfg     = '{PRIMARY_RST, SECONDARY_RST, HIGH_RST, LOW_RST, OFFSET_RST};
    chain_phase   = PH_IDLE;
    chain_fmt     = FMT_PLAIN;
    chain_first   = '0;
    chain_second  = '0;
    chain_third   = '0;
    chain_data    = '0;
    chain_upper   = '0;
    failures        = 0;
    requests_sent   = 0;
    results_checked = 0;
    finals_seen     = 0;
    clashes_seen    = 0;
    strays_seen     = 0;
    settings_used   = 1;
    send_idle_pct   = 36;
    recv_idle_pct   = 72;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table on the default register values.
    for (int i = 0; i < $size(PLAN); i++) send_request(PLAN[i].rq, PLAN[i].pinned, PLAN[i].want);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Swap the idle split after two phases, drop idling after four.
      if (p == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 36;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      apply_setting(p);
      run_random_traffic(PHASE_REQUESTS);
    end
    settle();

    $display("Sent %0d requests under %0d register settings; checked %0d results.",
             requests_sent, settings_used, results_checked);
    $display("Seen %0d final replies, %0d stray replies and %0d busy clashes.",
             finals_seen, strays_seen, clashes_seen);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
